// ----- rtl/pvb_pkg.sv -----
// ----------------------------------------------------------------------------
// pvb_pkg
// Shared types and codes for the page valid bitmap: the request and result
// words and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pvb_pkg;

  // Field widths of the request word, and the bitmap word width
  localparam int ADDR_W   = 64;
  localparam int COUNT_W  = 41;
  localparam int CMD_W    = 2;
  localparam int BITMAP_W = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_MARK_VALID   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK_INVALID = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK        = 2'd2;

  // Request word
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] byte_count;
  } pvb_item_t;

  // Result word
  typedef struct packed {
    logic page_valid;
    logic range_clipped;
  } pvb_result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture request word
    logic setup;    // latch run bounds, point at first bitmap word
    logic read;     // read bitmap word at current pointer
    logic write;    // write merged bitmap word
    logic advance;  // step to next bitmap word
    logic clear;    // zero one word of the reset clearing pass
    logic respond;  // launch the result word
  } pvb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // clearing pass is at the last word
    logic run_empty;   // mark touches no page
    logic is_check;
    logic is_mark;
    logic at_last;     // pointer is at the last word of the run
  } pvb_stat_t;

endpackage

// ----- rtl/pvb_ctrl.sv -----
// ----------------------------------------------------------------------------
// pvb_ctrl
// Sequencer for the page valid bitmap: reset clearing pass, request intake,
// read-modify-write of each touched bitmap word, and single-read checks.
// ----------------------------------------------------------------------------
module pvb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pvb_pkg::pvb_stat_t stat,
  output pvb_pkg::pvb_cmd_t  cmd
);
  import pvb_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (stat.is_check || (stat.is_mark && !stat.run_empty)) begin
          state_next = S_READ;
        end else begin
          cmd.respond = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = stat.is_check ? S_CHECK : S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        if (stat.at_last) begin
          cmd.respond = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      S_CHECK: begin
        cmd.respond = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- rtl/pvb_dpath.sv -----
// ----------------------------------------------------------------------------
// pvb_dpath
// Datapath for the page valid bitmap: request registers, run bounds, the
// bitmap memory with its merge logic, clearing counter and result register.
// ----------------------------------------------------------------------------
module pvb_dpath #(
  parameter int ADDRESS_BITS = 28,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pvb_pkg::pvb_item_t   item,
  input  pvb_pkg::pvb_cmd_t    cmd,
  output pvb_pkg::pvb_stat_t   stat,
  output logic                 done,
  output pvb_pkg::pvb_result_t result
);
  import pvb_pkg::*;

  localparam int PB    = $clog2(PAGE_BYTES);
  localparam int PN    = ADDRESS_BITS - PB;
  localparam int PG_W  = (PN > 0) ? PN : 1;
  localparam int CNT_W = COUNT_W - PB;
  localparam int SUM_W = ((PG_W > CNT_W) ? PG_W : CNT_W) + 1;
  localparam longint unsigned PAGE_COUNT = (64'd1 << ADDRESS_BITS) >> PB;
  localparam longint unsigned WORD_COUNT = (PAGE_COUNT + 64'd31) / 64'd32;
  localparam longint unsigned DEPTH      = (WORD_COUNT > 0) ? WORD_COUNT : 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0]    LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [SUM_W-1:0] PAGE_LIMIT = SUM_W'(PAGE_COUNT);
  localparam bit               HAS_PAGES  = (PAGE_COUNT != 0);

  // Request registers
  logic [CMD_W-1:0] cmd_q;
  logic [PG_W-1:0]  page_q;
  logic [CNT_W-1:0] pages_q;

  // Run bounds and word pointer
  logic [AW-1:0] w_cur;
  logic [AW-1:0] w_first;
  logic [AW-1:0] w_last;
  logic [4:0]    lo_q;
  logic [4:0]    hi_q;

  logic [AW-1:0]         clr_addr;
  logic [BITMAP_W-1:0]   rdata;
  logic [BITMAP_W-1:0]   mem [DEPTH];

  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    stop;
  logic [SUM_W-1:0]    last;
  logic                clip_c;
  logic                is_check;
  logic                is_mark;
  logic [4:0]          lo_eff;
  logic [4:0]          hi_eff;
  logic [BITMAP_W-1:0] mask;
  logic [BITMAP_W-1:0] merged;
  logic [AW-1:0]       waddr;
  logic [BITMAP_W-1:0] wdata;

  // Capture request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q   <= item.command;
      page_q  <= PG_W'(item.address[ADDRESS_BITS-1:0] >> PB);
      pages_q <= CNT_W'(item.byte_count >> PB);
    end
  end

  // Run end, clipped to the last page
  always_comb begin
    sum    = SUM_W'(page_q) + SUM_W'(pages_q);
    clip_c = (pages_q != '0) && (sum > PAGE_LIMIT);
    stop   = clip_c ? PAGE_LIMIT : sum;
    last   = stop - SUM_W'(1);
  end

  assign is_check = (cmd_q == CMD_CHECK);
  assign is_mark  = (cmd_q == CMD_MARK_VALID) || (cmd_q == CMD_MARK_INVALID);

  // Latch bounds, walk words
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      w_cur   <= AW'(page_q >> 5);
      w_first <= AW'(page_q >> 5);
      w_last  <= AW'(last >> 5);
      lo_q    <= 5'(page_q);
      hi_q    <= 5'(last);
    end else if (cmd.advance) begin
      w_cur <= w_cur + AW'(1);
    end
  end

  // Bit mask of the run within the current word
  always_comb begin
    lo_eff = (w_cur == w_first) ? lo_q : 5'd0;
    hi_eff = (w_cur == w_last) ? hi_q : 5'd31;
    mask   = ({BITMAP_W{1'b1}} << lo_eff) & ({BITMAP_W{1'b1}} >> (5'd31 - hi_eff));
    merged = (cmd_q == CMD_MARK_VALID) ? (rdata | mask) : (rdata & ~mask);
    waddr  = cmd.clear ? clr_addr : w_cur;
    wdata  = cmd.clear ? '0 : merged;
  end

  // Bitmap memory
  always_ff @(posedge clk) begin
    if (cmd.clear || cmd.write) mem[waddr] <= wdata;
    if (cmd.read) rdata <= mem[w_cur];
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      result.page_valid    <= is_check & HAS_PAGES & rdata[lo_q];
      result.range_clipped <= is_mark & clip_c;
    end
  end

  // Status to controller
  always_comb begin
    stat.clear_last = (clr_addr == LAST_ADDR);
    stat.run_empty  = (pages_q == '0) || (stop <= SUM_W'(page_q));
    stat.is_check   = is_check;
    stat.is_mark    = is_mark;
    stat.at_last    = (w_cur == w_last);
  end

endmodule

// ----- rtl/page_valid_bitmap_core.sv -----
// ----------------------------------------------------------------------------
// page_valid_bitmap_core
// One valid bit per page of a 2^ADDRESS_BITS byte space, in a bitmap memory of
// 32-bit words; mark commands set or clear page runs, checks read one page.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears on
// result for one cycle with done high, and the receiver cannot stall it.
// After reset, busy stays high while a clearing pass zeroes the bitmap's
// (2^ADDRESS_BITS / PAGE_BYTES + 31) / 32 words (2048 at the defaults), one
// word per cycle. A check goes through setup, a read and the check state
// before its result is registered. A mark goes through setup and then a read
// and a write back for each bitmap word its page run touches, one word at a
// time; a mark of zero pages or an unused command responds from setup. The
// next word may be started in the cycle that done is high.
// ----------------------------------------------------------------------------
module page_valid_bitmap_core #(
  parameter int ADDRESS_BITS = 28,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  pvb_pkg::pvb_item_t   item,
  output logic                 done,
  output pvb_pkg::pvb_result_t result
);
  import pvb_pkg::*;

  pvb_cmd_t  cmd;
  pvb_stat_t stat;

  // Sequencer
  pvb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Bitmap datapath
  pvb_dpath #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

// ----- rtl/pvb_checker.sv -----
// ----------------------------------------------------------------------------
// pvb_checker
// Port-level checks for page_valid_bitmap_core, bound to the top level.
// ----------------------------------------------------------------------------
module pvb_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input pvb_pkg::pvb_result_t result
);
  import pvb_pkg::*;

  // An accepted word holds the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted word");

  // No result in the cycle after an accept
  a_accept_no_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result strobe right after an accept");

  // Results never come in back-to-back cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on two cycles in a row");

  // A result never flags both a valid page and a clipped range
  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.page_valid && result.range_clipped))
    else $error("page_valid and range_clipped both set");

endmodule

bind page_valid_bitmap_core pvb_checker u_pvb_checker (.*);
